// ----- src/dls_pkg.sv -----
// Shared types, constants and the exponent table function for the dense softmax block.
`timescale 1ns / 1ps
package dls_pkg;

  localparam int DEF_MAX_OUTPUTS     = 16;
  localparam int DEF_MAX_INPUTS      = 256;
  localparam int DEF_EXP_TABLE_DEPTH = 256;

  localparam logic [8:0] INPUT_LENGTH_RESET = 9'd256;
  localparam logic [4:0] OUTPUT_COUNT_RESET = 5'd16;

  // register addresses (word index)
  localparam logic REG_INPUT_LENGTH = 1'b0;
  localparam logic REG_OUTPUT_COUNT = 1'b1;

  // item function codes
  localparam logic [1:0] FUNC_WEIGHT = 2'd0;
  localparam logic [1:0] FUNC_BIAS   = 2'd1;
  localparam logic [1:0] FUNC_DATA   = 2'd2;

  localparam int ACC_W   = 40;
  localparam int LOGIT_W = 24;
  localparam int PROB_W  = 17;

  // exp(-1/16) in Q0.32
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

  // control strobes broadcast to every cell
  typedef struct packed {
    logic wr_weight;
    logic wr_bias;
    logic rd;
    logic mul;
    logic acc;
    logic load;
    logic shift;
  } cell_ctl_t;

  // entry k of the exponent table: exp(-k/16) in Q1.16, evaluated at elaboration
  function automatic logic [16:0] exp_entry(input int k);
    logic [63:0] p;
    p = 64'h1_0000_0000;
    for (int i = 0; i < k; i++) begin
      p = (p * EXP_STEP_Q32 + 64'h8000_0000) >> 32;
    end
    return 17'((p + 64'd32768) >> 16);
  endfunction

endpackage

// ----- src/dense_layer_softmax.sv -----
// Top level: intake sequencer, chain of row cells, softmax tail and register port.
//
// Usage: items arrive on in_valid/in_ready with func, row, column and value.
// Weight and bias writes store one Q8.8 entry in the addressed row cell; a data
// element is multiplied into every row's accumulator. A store write leaves the
// intake idle; a data element passes registered weight read, multiply and
// accumulate before the next item is taken. When input_length elements have
// arrived, every cell forms its saturated logit, and the logits in use shift
// down the cell chain into the softmax unit, one a cycle. The tail forms the
// exponent sum and, per output, one numerator prep and 33 divide steps before
// the result is shown on out_valid/out_ready with class_index, probability and
// is_last. While the tail runs or a result waits, in_ready stays low; a stalled
// receiver holds the result register. Reset clears accumulators, element count
// and control state and restores input_length 256, output_count 16; the weight
// and bias stores keep no reset. The user must write registers over the APB
// port only while idle; the block does not enforce it.
`timescale 1ns / 1ps
module dense_layer_softmax
  import dls_pkg::*;
#(
  parameter int MAX_OUTPUTS     = DEF_MAX_OUTPUTS,
  parameter int MAX_INPUTS      = DEF_MAX_INPUTS,
  parameter int EXP_TABLE_DEPTH = DEF_EXP_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic [3:0]         row,
  input  logic [7:0]         column,
  input  logic signed [15:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         class_index,
  output logic [PROB_W-1:0]  probability,
  output logic               is_last
);

  localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int NW = $clog2(MAX_OUTPUTS + 1);

  typedef enum logic [4:0] {
    T_IDLE  = 5'b00001,
    T_MUL   = 5'b00010,
    T_ACC   = 5'b00100,
    T_LOGIT = 5'b01000,
    T_SHIFT = 5'b10000
  } top_state_t;

  top_state_t                state;
  logic [8:0]                input_length;
  logic [4:0]                output_count;
  logic [8:0]                count;
  logic [8:0]                count_next;
  logic [12:0]               eff_len;
  logic [6:0]                eff_out;
  logic [NW-1:0]             n_reg;
  logic [NW-1:0]             sh_cnt;
  logic                      accept;
  logic                      col_ok;
  logic signed [15:0]        xval;
  logic [12:0]               col_ext;
  cell_ctl_t                 ctl;
  logic                      sm_busy;
  logic signed [LOGIT_W-1:0] lchain [MAX_OUTPUTS+1];

  // configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      input_length <= INPUT_LENGTH_RESET;
      output_count <= OUTPUT_COUNT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_INPUT_LENGTH: input_length <= pwdata[8:0];
        REG_OUTPUT_COUNT: output_count <= pwdata[4:0];
        default: ;
      endcase
    end
  end
  assign prdata = (paddr[2] == REG_OUTPUT_COUNT) ? {27'd0, output_count}
                                                 : {23'd0, input_length};

  // effective lengths
  always_comb begin
    if (input_length == 9'd0) begin
      eff_len = 13'd1;
    end else if (13'(input_length) > 13'(MAX_INPUTS)) begin
      eff_len = 13'(MAX_INPUTS);
    end else begin
      eff_len = 13'(input_length);
    end
    if (output_count == 5'd0) begin
      eff_out = 7'd1;
    end else if (7'(output_count) > 7'(MAX_OUTPUTS)) begin
      eff_out = 7'(MAX_OUTPUTS);
    end else begin
      eff_out = 7'(output_count);
    end
  end

  assign in_ready   = (state == T_IDLE) && !sm_busy;
  assign accept     = in_valid && in_ready;
  assign col_ext    = 13'(column);
  assign count_next = count + 9'd1;

  // cell strobes
  always_comb begin
    ctl           = '0;
    ctl.wr_weight = accept && (func == FUNC_WEIGHT) && (col_ext < 13'(MAX_INPUTS));
    ctl.wr_bias   = accept && (func == FUNC_BIAS);
    ctl.rd        = accept && (func == FUNC_DATA);
    ctl.mul       = (state == T_MUL);
    ctl.acc       = (state == T_ACC);
    ctl.load      = (state == T_LOGIT);
    ctl.shift     = (state == T_SHIFT);
  end

  // intake sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        T_IDLE: begin
          if (accept && func == FUNC_DATA) begin
            state <= T_MUL;
          end
        end
        T_MUL: state <= T_ACC;
        T_ACC: begin
          if (13'(count_next) >= eff_len) begin
            count <= '0;
            n_reg <= NW'(eff_out);
            state <= T_LOGIT;
          end else begin
            count <= count_next;
            state <= T_IDLE;
          end
        end
        T_LOGIT: begin
          sh_cnt <= '0;
          state  <= T_SHIFT;
        end
        T_SHIFT: begin
          sh_cnt <= sh_cnt + NW'(1);
          if (sh_cnt + NW'(1) == n_reg) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // data element operands
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      xval   <= value;
      col_ok <= (col_ext < 13'(MAX_INPUTS));
    end
  end

  // row cells, logits shift toward row zero
  assign lchain[MAX_OUTPUTS] = '0;
  for (genvar i = 0; i < MAX_OUTPUTS; i++) begin : g_cell
    dls_cell #(
      .ROW       (i),
      .MAX_INPUTS(MAX_INPUTS),
      .IW        (IW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .wr_row   (row),
      .addr     (col_ext[IW-1:0]),
      .wdata    (value),
      .col_ok   (col_ok),
      .xval     (xval),
      .logit_in (lchain[i+1]),
      .logit_out(lchain[i])
    );
  end

  dls_softmax #(
    .MAX_OUTPUTS    (MAX_OUTPUTS),
    .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH),
    .NW             (NW)
  ) u_softmax (
    .clk        (clk),
    .rst        (rst),
    .lin_valid  (state == T_SHIFT),
    .lin        (lchain[0]),
    .n          (n_reg),
    .busy       (sm_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .class_index(class_index),
    .probability(probability),
    .is_last    (is_last)
  );

  // no new item while a result is pending
  a_ready_no_out: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("input taken while result pending");

  // a data element always enters the multiply stage
  a_data_to_mul: assert property (@(posedge clk) disable iff (rst)
    (accept && func == FUNC_DATA) |=> state == T_MUL) else $error("data element lost");

  // results only appear once the chain is drained
  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == T_IDLE) else $error("result during intake");

  // logit load is followed by the shift-out
  a_load_shift: assert property (@(posedge clk) disable iff (rst)
    state == T_LOGIT |=> state == T_SHIFT) else $error("logits not shifted out");

endmodule

// ----- src/dls_cell.sv -----
// One output row: weight memory, bias, accumulator and a logit shift stage.
`timescale 1ns / 1ps
module dls_cell
  import dls_pkg::*;
#(
  parameter int ROW        = 0,
  parameter int MAX_INPUTS = DEF_MAX_INPUTS,
  parameter int IW         = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cell_ctl_t                 ctl,
  input  logic [3:0]                wr_row,
  input  logic [IW-1:0]             addr,
  input  logic signed [15:0]        wdata,
  input  logic                      col_ok,
  input  logic signed [15:0]        xval,
  input  logic signed [LOGIT_W-1:0] logit_in,
  output logic signed [LOGIT_W-1:0] logit_out
);

  logic signed [15:0]        wmem [MAX_INPUTS];
  logic signed [15:0]        wq;
  logic signed [15:0]        bias;
  logic signed [31:0]        prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [LOGIT_W-1:0] logit;
  logic signed [41:0]        lsum;
  logic                      sel;

  assign sel = (32'(wr_row) == ROW);

  // weight memory, registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_weight && sel) begin
      wmem[addr] <= wdata;
    end
    if (ctl.rd) begin
      wq <= wmem[addr];
    end
  end

  // bias and product
  always_ff @(posedge clk) begin
    if (ctl.wr_bias && sel) begin
      bias <= wdata;
    end
    if (ctl.mul) begin
      prod <= col_ok ? wq * xval : 32'sd0;
    end
  end

  // rounded accumulator plus bias
  assign lsum = ((42'(acc) + 42'sd128) >>> 8) + 42'(bias);

  // accumulator, cleared when its logit is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl.load) begin
      acc <= '0;
    end else if (ctl.acc) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // saturated logit, then shifted toward row zero
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (lsum > 42'sd8388607) begin
        logit <= 24'sh7FFFFF;
      end else if (lsum < -42'sd8388608) begin
        logit <= 24'sh800000;
      end else begin
        logit <= lsum[LOGIT_W-1:0];
      end
    end else if (ctl.shift) begin
      logit <= logit_in;
    end
  end

  assign logit_out = logit;

endmodule

// ----- src/dls_softmax.sv -----
// Softmax tail: max search, table exponent, sum, bit-serial divide, result register.
`timescale 1ns / 1ps
module dls_softmax
  import dls_pkg::*;
#(
  parameter int MAX_OUTPUTS     = DEF_MAX_OUTPUTS,
  parameter int EXP_TABLE_DEPTH = DEF_EXP_TABLE_DEPTH,
  parameter int NW              = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      lin_valid,
  input  logic signed [LOGIT_W-1:0] lin,
  input  logic [NW-1:0]             n,
  output logic                      busy,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [3:0]                class_index,
  output logic [PROB_W-1:0]         probability,
  output logic                      is_last
);

  localparam int RW   = $clog2(MAX_OUTPUTS);
  localparam int EW   = $clog2(EXP_TABLE_DEPTH);
  localparam int SW   = $clog2(MAX_OUTPUTS * 65536 + 1);
  localparam int NUMW = 33;

  typedef enum logic [4:0] {
    SM_LOAD = 5'b00001,
    SM_EXP  = 5'b00010,
    SM_PREP = 5'b00100,
    SM_DIV  = 5'b01000,
    SM_OUT  = 5'b10000
  } sm_state_t;

  sm_state_t                 state;
  logic [NW-1:0]             cnt;
  logic [RW-1:0]             r;
  logic signed [LOGIT_W-1:0] mx;
  logic signed [LOGIT_W-1:0] lst [MAX_OUTPUTS];
  logic [16:0]               est [MAX_OUTPUTS];
  logic [16:0]               exp_rom [EXP_TABLE_DEPTH];
  logic [SW-1:0]             sum;
  logic [SW-1:0]             rem;
  logic [SW:0]               rs;
  logic [NUMW-1:0]           num;
  logic [PROB_W-1:0]         q;
  logic [5:0]                step;
  logic signed [LOGIT_W:0]   diff;
  logic [LOGIT_W:0]          idx;
  logic [16:0]               e;
  logic                      r_last;
  logic [7:0]                r8;

  // constant exponent table
  for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_rom
    assign exp_rom[k] = exp_entry(k);
  end

  assign diff   = (LOGIT_W+1)'(mx) - (LOGIT_W+1)'(lst[r]);
  assign idx    = (LOGIT_W+1)'((diff + 25'sd8) >>> 4);
  assign e      = (idx < (LOGIT_W+1)'(EXP_TABLE_DEPTH)) ? exp_rom[idx[EW-1:0]] : 17'd0;
  assign rs     = {rem, num[NUMW-1]};
  assign r_last = (NW'(r) + NW'(1)) == n;
  assign r8     = 8'(r);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SM_LOAD;
      cnt   <= '0;
    end else begin
      unique case (state)
        // collect logits and track the maximum
        SM_LOAD: begin
          if (lin_valid) begin
            lst[cnt[RW-1:0]] <= lin;
            if (cnt == '0 || lin > mx) begin
              mx <= lin;
            end
            cnt <= cnt + NW'(1);
            if (cnt + NW'(1) == n) begin
              state <= SM_EXP;
              r     <= '0;
              sum   <= '0;
            end
          end
        end
        // exponent lookup and running sum
        SM_EXP: begin
          est[r] <= e;
          sum    <= sum + SW'(e);
          if (r_last) begin
            r     <= '0;
            state <= SM_PREP;
          end else begin
            r <= r + RW'(1);
          end
        end
        // rounded numerator
        SM_PREP: begin
          num   <= NUMW'({est[r], 16'd0}) + NUMW'(sum >> 1);
          rem   <= '0;
          step  <= '0;
          state <= SM_DIV;
        end
        // restoring divide, one quotient bit a cycle
        SM_DIV: begin
          if (rs >= {1'b0, sum}) begin
            rem <= SW'(rs - {1'b0, sum});
            q   <= {q[PROB_W-2:0], 1'b1};
          end else begin
            rem <= rs[SW-1:0];
            q   <= {q[PROB_W-2:0], 1'b0};
          end
          num  <= num << 1;
          step <= step + 6'd1;
          if (step == 6'(NUMW - 1)) begin
            state <= SM_OUT;
          end
        end
        // hold the result until transfer
        SM_OUT: begin
          if (out_ready) begin
            if (r_last) begin
              cnt   <= '0;
              state <= SM_LOAD;
            end else begin
              r     <= r + RW'(1);
              state <= SM_PREP;
            end
          end
        end
        default: state <= SM_LOAD;
      endcase
    end
  end

  assign busy        = (state != SM_LOAD) || (cnt != '0);
  assign out_valid   = (state == SM_OUT);
  assign class_index = r8[3:0];
  assign probability = q;
  assign is_last     = r_last;

endmodule
